// ===== sv/vrtdf_pkg.sv =====
// ----------------------------------------------------------------------------
// vrtdf_pkg
// Shared types and constants for the VRT packet deframer and channel tagger.
// ----------------------------------------------------------------------------
package vrtdf_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;
    localparam int BYTE_W     = 8;
    localparam int SID_W      = 32;
    localparam int TICK_W     = 64;
    localparam int SAMP_W     = 14;
    localparam int CHAN_W     = 4;
    localparam int M_TDATA_W  = 120;
    localparam int M_TUSER_W  = 2;

    localparam logic [7:0] HEADER_BYTES_RST = 8'd28;
    localparam logic [7:0] TIME_OFFSET_RST  = 8'd16;
    localparam logic       TIME_ENABLE_RST  = 1'b1;
    localparam logic [4:0] CHAN_COUNT_RST   = 5'd4;
    localparam logic [7:0] PKT_PER_CH_RST   = 8'd8;
    localparam logic       FRAMING_RST      = 1'b0;

    localparam logic [7:0] PKT_PER_CH_DFLT  = 8'd8;

    localparam logic FRAMING_PLANAR      = 1'b0;
    localparam logic FRAMING_INTERLEAVED = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HEADER_BYTES = 3'd0,
        CFG_TIME_OFFSET  = 3'd1,
        CFG_TIME_ENABLE  = 3'd2,
        CFG_CHAN_COUNT   = 3'd3,
        CFG_PKT_PER_CH   = 3'd4,
        CFG_FRAMING_MODE = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic              packet_ok;
        logic [SID_W-1:0]  strm_id;
        logic              have_time;
        logic [TICK_W-1:0] time_ticks;
        logic [SAMP_W-1:0] sample_count;
        logic [CHAN_W-1:0] channel;
        logic              group_start;
        logic              grp_end;
    } t_desc;

endpackage

// ===== sv/vrt_packet_deframer_channel_tagger_top.sv =====
// A descriptor is registered in the output register, or in the skid entry if held.
// Throughput: one byte per cycle; the two-entry output register keeps bytes
// flowing while a descriptor waits, so the slave side stalls only when both hold one.
// Reset: synchronous, active low; clears all counters and the block timestamp and
// loads the register defaults.
// ----------------------------------------------------------------------------
// vrt_packet_deframer_channel_tagger_top
// Captures stream id and timestamp per packet, checks payload length and tags
// each packet with its channel and group position (planar framing only).
// ----------------------------------------------------------------------------
module vrt_packet_deframer_channel_tagger_top #(
    parameter int LEN_BITS     = 16,
    parameter int MAX_CHANNELS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // slave side: tdata = data_byte[7:0]; tlast = last_byte
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    input  logic [vrtdf_pkg::BYTE_W-1:0]        i_s_tdata,
    input  logic                                i_s_tlast,
    // master side
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // tdata: strm_id[31:0], have_time[32], time_ticks[96:33],
    //        sample_count[110:97], channel[114:111], zero[119:115]
    output logic [vrtdf_pkg::M_TDATA_W-1:0]     o_m_tdata,
    // tuser: packet_ok[0], group_start[1]
    output logic [vrtdf_pkg::M_TUSER_W-1:0]     o_m_tuser,
    output logic                                o_m_tlast,
    // configuration write channel
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [vrtdf_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [vrtdf_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int PW   = LEN_BITS + 1;
    localparam int CH_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int CCW  = ($clog2(MAX_CHANNELS + 1) > 5) ? $clog2(MAX_CHANNELS + 1) : 5;

    // configuration
    logic [7:0] r_header_bytes;
    logic [7:0] r_time_offset;
    logic       r_time_enable;
    logic [4:0] r_chan_count;
    logic [7:0] r_pkt_per_ch;
    logic       r_framing;

    // packet state
    logic [PW-1:0]                 r_byte_pos,   n_byte_pos;
    logic [vrtdf_pkg::SID_W-1:0]   r_id_shift,   n_id_shift;
    logic [vrtdf_pkg::TICK_W-1:0]  r_time_shift, n_time_shift;
    logic [7:0]                    r_group_pos,  n_group_pos;
    logic [CH_W-1:0]               r_chan_pos,   n_chan_pos;
    logic                          r_blk_valid,  n_blk_valid;
    logic [vrtdf_pkg::TICK_W-1:0]  r_blk_time,   n_blk_time;

    // output stage
    logic             r_main_valid, r_skid_valid;
    vrtdf_pkg::t_desc r_main, r_skid;
    vrtdf_pkg::t_desc n_res;

    logic in_fire, out_fire, res_valid;

    logic [PW-1:0]                pos_to, pos_to_end, len, pay;
    logic                         in_id, in_time;
    logic [vrtdf_pkg::SID_W-1:0]  id_nx;
    logic [vrtdf_pkg::TICK_W-1:0] time_nx;
    logic [7:0]                   n_eff, gp_eff, gp_inc;
    logic [CCW-1:0]               cc_ext, cc_eff, cp_ext, cp_eff, cp_inc;
    logic                         len_ok, pkt_ok, have_cap, blk_beg;
    logic [PW+vrtdf_pkg::SAMP_W-1:0] samp_w;

    assign in_fire   = i_s_tvalid && o_s_tready;
    assign out_fire  = r_main_valid && i_m_tready;
    assign res_valid = in_fire && i_s_tlast;

    assign o_s_tready  = !r_skid_valid;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header_bytes <= vrtdf_pkg::HEADER_BYTES_RST;
            r_time_offset  <= vrtdf_pkg::TIME_OFFSET_RST;
            r_time_enable  <= vrtdf_pkg::TIME_ENABLE_RST;
            r_chan_count   <= vrtdf_pkg::CHAN_COUNT_RST;
            r_pkt_per_ch   <= vrtdf_pkg::PKT_PER_CH_RST;
            r_framing      <= vrtdf_pkg::FRAMING_RST;
        end else if (i_cfg_valid) begin
            case (vrtdf_pkg::t_cfg_idx'(i_cfg_index))
                vrtdf_pkg::CFG_HEADER_BYTES: r_header_bytes <= i_cfg_data;
                vrtdf_pkg::CFG_TIME_OFFSET:  r_time_offset  <= i_cfg_data;
                vrtdf_pkg::CFG_TIME_ENABLE:  r_time_enable  <= i_cfg_data[0];
                vrtdf_pkg::CFG_CHAN_COUNT:   r_chan_count   <= i_cfg_data[4:0];
                vrtdf_pkg::CFG_PKT_PER_CH:   r_pkt_per_ch   <= i_cfg_data;
                vrtdf_pkg::CFG_FRAMING_MODE: r_framing      <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        // per-byte capture
        pos_to     = PW'(r_time_offset);
        pos_to_end = pos_to + PW'(8);
        in_id      = (r_byte_pos >= PW'(4)) && (r_byte_pos < PW'(8));
        in_time    = (r_byte_pos >= pos_to) && (r_byte_pos < pos_to_end);
        id_nx      = in_id ? {r_id_shift[vrtdf_pkg::SID_W-9:0], i_s_tdata} : r_id_shift;
        time_nx    = in_time ? {r_time_shift[vrtdf_pkg::TICK_W-9:0], i_s_tdata}
                             : r_time_shift;
        len        = r_byte_pos[PW-1] ? r_byte_pos : r_byte_pos + PW'(1);

        // channel / group counters
        n_eff  = (r_pkt_per_ch == 8'd0) ? vrtdf_pkg::PKT_PER_CH_DFLT : r_pkt_per_ch;
        cc_ext = CCW'(r_chan_count);
        if (cc_ext == CCW'(0))
            cc_eff = CCW'(1);
        else if (cc_ext > CCW'(MAX_CHANNELS))
            cc_eff = CCW'(MAX_CHANNELS);
        else
            cc_eff = cc_ext;
        gp_eff = (r_group_pos >= n_eff) ? 8'd0 : r_group_pos;
        cp_ext = CCW'(r_chan_pos);
        cp_eff = (cp_ext >= cc_eff) ? CCW'(0) : cp_ext;
        gp_inc = gp_eff + 8'd1;
        cp_inc = cp_eff + CCW'(1);
        blk_beg = (gp_eff == 8'd0) && (cp_eff == CCW'(0));

        // length checks
        len_ok   = !len[PW-1] && (len >= PW'(r_header_bytes));
        pay      = len - PW'(r_header_bytes);
        pkt_ok   = len_ok && (pay[1:0] == 2'b00) && (pay[PW-1:2] != '0);
        samp_w   = (PW + vrtdf_pkg::SAMP_W)'(pay) >> 2;
        have_cap = r_time_enable && (len >= pos_to_end);

        n_res.packet_ok    = pkt_ok;
        n_res.strm_id      = (len >= PW'(8)) ? id_nx : '0;
        n_res.have_time    = 1'b0;
        n_res.time_ticks   = '0;
        n_res.sample_count = pkt_ok ? samp_w[vrtdf_pkg::SAMP_W-1:0] : '0;
        n_res.channel      = '0;
        n_res.group_start  = 1'b0;
        n_res.grp_end      = 1'b0;

        n_blk_valid = r_blk_valid;
        n_blk_time  = r_blk_time;
        if (pkt_ok) begin
            if (blk_beg) begin
                n_res.have_time  = have_cap;
                n_res.time_ticks = have_cap ? time_nx : '0;
                n_blk_valid      = have_cap;
                n_blk_time       = have_cap ? time_nx : '0;
            end else begin
                n_res.have_time  = have_cap || r_blk_valid;
                n_res.time_ticks = r_blk_valid ? r_blk_time : (have_cap ? time_nx : '0);
            end
        end

        if (r_framing == vrtdf_pkg::FRAMING_PLANAR) begin
            n_res.channel     = vrtdf_pkg::CHAN_W'(cp_eff);
            n_res.group_start = (gp_eff == 8'd0);
            n_res.grp_end     = (gp_eff == n_eff - 8'd1);
        end

        // next state
        n_byte_pos   = r_byte_pos;
        n_id_shift   = r_id_shift;
        n_time_shift = r_time_shift;
        n_group_pos  = r_group_pos;
        n_chan_pos   = r_chan_pos;
        if (in_fire) begin
            if (i_s_tlast) begin
                n_byte_pos   = '0;
                n_id_shift   = '0;
                n_time_shift = '0;
                if (gp_inc >= n_eff) begin
                    n_group_pos = 8'd0;
                    n_chan_pos  = (cp_inc >= cc_eff) ? '0 : CH_W'(cp_inc);
                end else begin
                    n_group_pos = gp_inc;
                    n_chan_pos  = CH_W'(cp_eff);
                end
            end else begin
                n_byte_pos   = len;
                n_id_shift   = id_nx;
                n_time_shift = time_nx;
            end
        end
        if (!res_valid) begin
            n_blk_valid = r_blk_valid;
            n_blk_time  = r_blk_time;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_pos   <= '0;
            r_id_shift   <= '0;
            r_time_shift <= '0;
            r_group_pos  <= '0;
            r_chan_pos   <= '0;
            r_blk_valid  <= 1'b0;
            r_blk_time   <= '0;
        end else begin
            r_byte_pos   <= n_byte_pos;
            r_id_shift   <= n_id_shift;
            r_time_shift <= n_time_shift;
            r_group_pos  <= n_group_pos;
            r_chan_pos   <= n_chan_pos;
            r_blk_valid  <= n_blk_valid;
            r_blk_time   <= n_blk_time;
        end
    end

    // output register with skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_fire)
                r_skid_valid <= 1'b0;
        end else if (res_valid) begin
            if (r_main_valid && !out_fire)
                r_skid_valid <= 1'b1;
            else
                r_main_valid <= 1'b1;
        end else if (out_fire) begin
            r_main_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_fire)
                r_main <= r_skid;
        end else if (res_valid) begin
            if (r_main_valid && !out_fire)
                r_skid <= n_res;
            else
                r_main <= n_res;
        end
    end

    assign o_m_tvalid = r_main_valid;
    assign o_m_tdata  = {5'd0, r_main.channel, r_main.sample_count, r_main.time_ticks,
                         r_main.have_time, r_main.strm_id};
    assign o_m_tuser  = {r_main.group_start, r_main.packet_ok};
    assign o_m_tlast  = r_main.grp_end;

endmodule

// ===== sv/vrtdf_checker.sv =====
// ----------------------------------------------------------------------------
// vrtdf_checker
// Port-level checks for the deframer, bound to the top level.
// ----------------------------------------------------------------------------
module vrtdf_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              o_s_tready,
    input logic                              o_m_tvalid,
    input logic                              i_m_tready,
    input logic [vrtdf_pkg::M_TDATA_W-1:0]   o_m_tdata,
    input logic [vrtdf_pkg::M_TUSER_W-1:0]   o_m_tuser,
    input logic                              o_m_tlast
);

    // dropped packet carries no time and no samples
    a_drop_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser[0]) |->
            (!o_m_tdata[32] && o_m_tdata[96:33] == 64'd0 && o_m_tdata[110:97] == 14'd0))
        else $error("dropped packet with time or samples");

    // accepted packet always has samples
    a_ok_samples: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[0]) |-> (o_m_tdata[110:97] != 14'd0))
        else $error("accepted packet with zero samples");

    // no timestamp means zero ticks
    a_no_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tdata[32]) |-> (o_m_tdata[96:33] == 64'd0))
        else $error("ticks without timestamp");

    // input only stalls while a descriptor is pending
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> o_m_tvalid)
        else $error("input stalled with empty output");

    // a stalled descriptor holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=>
            (o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser) && $stable(o_m_tlast)))
        else $error("stalled descriptor changed");

endmodule

bind vrt_packet_deframer_channel_tagger_top vrtdf_checker u_vrtdf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_s_tready  (o_s_tready),
    .o_m_tvalid  (o_m_tvalid),
    .i_m_tready  (i_m_tready),
    .o_m_tdata   (o_m_tdata),
    .o_m_tuser   (o_m_tuser),
    .o_m_tlast   (o_m_tlast)
);
